/* design/mwm_pkg.sv */
// mwm_pkg: shared constants, action and compass codes, controller command type
// used by mwm_ctrl, mwm_datapath and maze_wall_map_and_walker; no dependencies
package mwm_pkg;

    localparam int GRID_SIDE = 16;
    localparam int CELL_W    = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;

    localparam logic [2:0] ACT_SET_WALL  = 3'd0;
    localparam logic [2:0] ACT_QUERY_ABS = 3'd1;
    localparam logic [2:0] ACT_QUERY_REL = 3'd2;
    localparam logic [2:0] ACT_TURN_REL  = 3'd3;
    localparam logic [2:0] ACT_TURN_ABS  = 3'd4;
    localparam logic [2:0] ACT_STEP      = 3'd5;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam int WEST_IDX  = 1;
    localparam int SOUTH_IDX = 0;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage

/* design/mwm_ctrl.sv */
// mwm_ctrl: two-state controller, load a request then execute it
// depends on mwm_pkg
module mwm_ctrl import mwm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

/* design/mwm_datapath.sv */
// mwm_datapath: wall store with per-cell valid bits, walker registers, result registers
// depends on mwm_pkg; driven by commands from mwm_ctrl
module mwm_datapath import mwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [2:0]        i_action,
    input  logic [CELL_W-1:0] i_cell_x,
    input  logic [CELL_W-1:0] i_cell_y,
    input  logic [1:0]        i_direction,
    input  logic              i_wall_present,
    output logic              o_done,
    output logic              o_wall_seen,
    output logic              o_step_ok,
    output logic [CELL_W-1:0] o_walker_x,
    output logic [CELL_W-1:0] o_walker_y,
    output logic [1:0]        o_walker_heading,
    output logic              o_walker_crashed
);

    logic [1:0]        r_mem [CELLS];
    logic              r_valid [CELLS];

    logic [2:0]        r_action;
    logic [1:0]        r_dir;
    logic              r_present;
    logic [ADDR_W-1:0] r_addr;
    logic              r_west;
    logic              r_forced;
    logic              r_offmap;
    logic [1:0]        r_rd;
    logic              r_rd_vld;

    logic [CELL_W-1:0] r_pos_x;
    logic [CELL_W-1:0] r_pos_y;
    logic [1:0]        r_heading;
    logic              r_crashed;
    logic              r_done;
    logic              r_seen;
    logic              r_ok;

    logic [CELL_W-1:0] src_x;
    logic [CELL_W-1:0] src_y;
    logic [1:0]        edir;
    logic [CELL_W:0]   tx;
    logic [CELL_W:0]   ty;
    logic              tgt_west;
    logic              tgt_offmap;
    logic              tgt_forced;
    logic [ADDR_W-1:0] tgt_addr;

    logic [1:0]        cell_bits;
    logic [1:0]        n_cell;
    logic              wall;
    logic              we;
    logic [CELL_W-1:0] n_pos_x;
    logic [CELL_W-1:0] n_pos_y;
    logic [1:0]        n_heading;
    logic              n_crashed;
    logic              n_seen;
    logic              n_ok;

    // target cell and wall bit of the request
    always_comb begin
        if (i_action == ACT_QUERY_REL || i_action == ACT_STEP) begin
            src_x = r_pos_x;
            src_y = r_pos_y;
        end else begin
            src_x = i_cell_x;
            src_y = i_cell_y;
        end
        if (i_action == ACT_QUERY_REL) begin
            edir = r_heading + i_direction;
        end else if (i_action == ACT_STEP) begin
            edir = r_heading;
        end else begin
            edir = i_direction;
        end
        tx       = {1'b0, src_x};
        ty       = {1'b0, src_y};
        tgt_west = 1'b0;
        case (edir)
            DIR_NORTH: begin
                ty = {1'b0, src_y} + 1'b1;
            end
            DIR_EAST: begin
                tx       = {1'b0, src_x} + 1'b1;
                tgt_west = 1'b1;
            end
            DIR_SOUTH: begin
                tgt_west = 1'b0;
            end
            default: begin
                tgt_west = 1'b1;
            end
        endcase
        tgt_offmap = (tx >= (CELL_W+1)'(GRID_SIDE)) || (ty >= (CELL_W+1)'(GRID_SIDE));
        tgt_forced = tgt_offmap || (tgt_west && tx == '0) || (!tgt_west && ty == '0);
        tgt_addr   = {tx[CELL_W-1:0], ty[CELL_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_dir     <= i_direction;
            r_present <= i_wall_present;
            r_addr    <= tgt_addr;
            r_west    <= tgt_west;
            r_forced  <= tgt_forced;
            r_offmap  <= tgt_offmap;
            r_rd      <= r_mem[tgt_addr];
            r_rd_vld  <= r_valid[tgt_addr];
        end
        if (we) begin
            r_mem[r_addr] <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    // execute
    always_comb begin
        cell_bits = r_rd_vld ? r_rd : 2'b00;
        wall      = r_forced || (r_west ? cell_bits[WEST_IDX] : cell_bits[SOUTH_IDX]);
        n_cell    = cell_bits;
        if (r_west) begin
            n_cell[WEST_IDX] = r_present;
        end else begin
            n_cell[SOUTH_IDX] = r_present;
        end
        we        = i_cmd.exec && (r_action == ACT_SET_WALL) && !r_offmap;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_heading = r_heading;
        n_crashed = r_crashed;
        n_seen    = 1'b0;
        n_ok      = 1'b0;
        case (r_action)
            ACT_QUERY_ABS, ACT_QUERY_REL: begin
                n_seen = wall;
            end
            ACT_TURN_REL: begin
                if (!r_crashed) begin
                    n_heading = r_heading + r_dir;
                end
            end
            ACT_TURN_ABS: begin
                if (!r_crashed) begin
                    n_heading = r_dir;
                end
            end
            ACT_STEP: begin
                if (!r_crashed) begin
                    if (wall) begin
                        n_crashed = 1'b1;
                    end else begin
                        n_ok = 1'b1;
                        case (r_heading)
                            DIR_NORTH: n_pos_y = r_pos_y + 1'b1;
                            DIR_EAST:  n_pos_x = r_pos_x + 1'b1;
                            DIR_SOUTH: n_pos_y = r_pos_y - 1'b1;
                            default:   n_pos_x = r_pos_x - 1'b1;
                        endcase
                    end
                end
            end
            default: begin
                n_seen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= DIR_NORTH;
            r_crashed <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_heading <= n_heading;
                r_crashed <= n_crashed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_seen <= n_seen;
            r_ok   <= n_ok;
        end
    end

    assign o_done           = r_done;
    assign o_wall_seen      = r_seen;
    assign o_step_ok        = r_ok;
    assign o_walker_x       = r_pos_x;
    assign o_walker_y       = r_pos_y;
    assign o_walker_heading = r_heading;
    assign o_walker_crashed = r_crashed;

    a_step_not_crashed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_step_ok) |-> !o_walker_crashed)
        else $error("successful step with crashed walker");

    a_seen_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_wall_seen) |->
            ($past(r_action) == ACT_QUERY_ABS || $past(r_action) == ACT_QUERY_REL))
        else $error("wall seen on a non-query request");

    a_crash_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_crashed))
        else $error("crashed flag cleared without reset");

    a_crashed_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_crashed && $past(r_crashed)) |-> $stable(r_heading))
        else $error("heading changed while crashed");

endmodule

/* design/maze_wall_map_and_walker.sv */
// maze_wall_map_and_walker: top level, 16x16 wall map with a walker
// depends on mwm_pkg, mwm_ctrl, mwm_datapath
//
// channel  | handshake          | payload
// request  | start / busy       | i_action i_cell_x i_cell_y i_direction i_wall_present
// result   | o_done (one cycle) | o_wall_seen o_step_ok o_walker_x o_walker_y
//          |                    | o_walker_heading o_walker_crashed
//
// a request is taken when start is high and busy is low; busy stays high in the execute state
// (wall store read, then execute and write back), so the next request waits until this one has executed
// the result shows in the cycle after the execute cycle, while the next request can be taken
// reset clears the walker and the per-cell valid bits at once; no clearing pass
// the receiver cannot stall: o_done lasts exactly one cycle
module maze_wall_map_and_walker import mwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_action,
    input  logic [CELL_W-1:0] i_cell_x,
    input  logic [CELL_W-1:0] i_cell_y,
    input  logic [1:0]        i_direction,
    input  logic              i_wall_present,
    output logic              o_done,
    output logic              o_wall_seen,
    output logic              o_step_ok,
    output logic [CELL_W-1:0] o_walker_x,
    output logic [CELL_W-1:0] o_walker_y,
    output logic [1:0]        o_walker_heading,
    output logic              o_walker_crashed
);

    t_ctrl_cmd cmd;

    mwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mwm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_direction      (i_direction),
        .i_wall_present   (i_wall_present),
        .o_done           (o_done),
        .o_wall_seen      (o_wall_seen),
        .o_step_ok        (o_step_ok),
        .o_walker_x       (o_walker_x),
        .o_walker_y       (o_walker_y),
        .o_walker_heading (o_walker_heading),
        .o_walker_crashed (o_walker_crashed)
    );

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for maze_wall_map_and_walker, a 16x16 wall map with a walker
// depends on mwm_pkg and the maze_wall_map_and_walker rtl; a built-in map model predicts
// every result, and directed, random and crash tests are run over the start/busy request port
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwm_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic [1:0] REL_FRONT = 2'd0;
    localparam logic [1:0] REL_RIGHT = 2'd1;
    localparam logic [1:0] REL_BACK  = 2'd2;
    localparam logic [1:0] REL_LEFT  = 2'd3;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic              wall_seen;
        logic              step_ok;
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
        logic [1:0]        heading;
        logic              crashed;
    } t_walker_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_action;
    logic [CELL_W-1:0] i_cell_x;
    logic [CELL_W-1:0] i_cell_y;
    logic [1:0]        i_direction;
    logic              i_wall_present;
    logic              o_done;
    logic              o_wall_seen;
    logic              o_step_ok;
    logic [CELL_W-1:0] o_walker_x;
    logic [CELL_W-1:0] o_walker_y;
    logic [1:0]        o_walker_heading;
    logic              o_walker_crashed;

    logic [1:0]        wall_map [GRID_SIDE][GRID_SIDE];
    logic [CELL_W-1:0] walk_x;
    logic [CELL_W-1:0] walk_y;
    logic [1:0]        walk_heading;
    logic              walk_crashed;

    t_walker_result    pending_results [$];
    int                mismatch_count = 0;
    int                idle_pct = 0;

    maze_wall_map_and_walker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_direction      (i_direction),
        .i_wall_present   (i_wall_present),
        .o_done           (o_done),
        .o_wall_seen      (o_wall_seen),
        .o_step_ok        (o_step_ok),
        .o_walker_x       (o_walker_x),
        .o_walker_y       (o_walker_y),
        .o_walker_heading (o_walker_heading),
        .o_walker_crashed (o_walker_crashed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic cell_on_map(int x, int y);
        return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE;
    endfunction

    // off-map cells and map edges to the west and south always read as walls
    function automatic logic stored_wall(int x, int y, int idx);
        if (!cell_on_map(x, y)) return 1'b1;
        if (idx == WEST_IDX && x == 0) return 1'b1;
        if (idx == SOUTH_IDX && y == 0) return 1'b1;
        return wall_map[x][y][idx];
    endfunction

    function automatic logic wall_toward(int x, int y, logic [1:0] dir);
        case (dir)
            DIR_NORTH: return stored_wall(x, y + 1, SOUTH_IDX);
            DIR_EAST:  return stored_wall(x + 1, y, WEST_IDX);
            DIR_SOUTH: return stored_wall(x, y, SOUTH_IDX);
            default:   return stored_wall(x, y, WEST_IDX);
        endcase
    endfunction

    function automatic t_walker_result apply_request(logic [2:0] act, logic [CELL_W-1:0] cx,
                                                     logic [CELL_W-1:0] cy, logic [1:0] dir,
                                                     logic present);
        t_walker_result r;
        int tx;
        int ty;
        int idx;
        r = '0;
        case (act)
            ACT_SET_WALL: begin
                tx = int'(cx);
                ty = int'(cy);
                idx = SOUTH_IDX;
                case (dir)
                    DIR_NORTH: ty = ty + 1;
                    DIR_EAST: begin
                        tx = tx + 1;
                        idx = WEST_IDX;
                    end
                    DIR_SOUTH: ;
                    default: idx = WEST_IDX;
                endcase
                if (cell_on_map(tx, ty)) wall_map[tx][ty][idx] = present;
            end
            ACT_QUERY_ABS: r.wall_seen = wall_toward(int'(cx), int'(cy), dir);
            ACT_QUERY_REL: r.wall_seen = wall_toward(int'(walk_x), int'(walk_y),
                                                     walk_heading + dir);
            ACT_TURN_REL: if (!walk_crashed) walk_heading = walk_heading + dir;
            ACT_TURN_ABS: if (!walk_crashed) walk_heading = dir;
            ACT_STEP: begin
                if (!walk_crashed) begin
                    if (wall_toward(int'(walk_x), int'(walk_y), walk_heading)) begin
                        walk_crashed = 1'b1;
                    end else begin
                        case (walk_heading)
                            DIR_NORTH: walk_y = walk_y + 1'b1;
                            DIR_EAST:  walk_x = walk_x + 1'b1;
                            DIR_SOUTH: walk_y = walk_y - 1'b1;
                            default:   walk_x = walk_x - 1'b1;
                        endcase
                        r.step_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.x = walk_x;
        r.y = walk_y;
        r.heading = walk_heading;
        r.crashed = walk_crashed;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_walker_result got;
        t_walker_result want;
        got = {o_wall_seen, o_step_ok, o_walker_x, o_walker_y, o_walker_heading,
               o_walker_crashed};
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_SHOWN)
                    $display("unexpected result: seen %0b ok %0b pos (%0d,%0d) hd %0d crash %0b",
                             got.wall_seen, got.step_ok, got.x, got.y, got.heading, got.crashed);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.wall_seen !== want.wall_seen || got.step_ok !== want.step_ok ||
                    got.x !== want.x || got.y !== want.y ||
                    got.heading !== want.heading || got.crashed !== want.crashed) begin
                    if (mismatch_count < MAX_SHOWN)
                        $display("mismatch: exp seen %0b ok %0b pos (%0d,%0d) hd %0d crash %0b, %s",
                                 want.wall_seen, want.step_ok, want.x, want.y, want.heading,
                                 want.crashed,
                                 $sformatf("got seen %0b ok %0b pos (%0d,%0d) hd %0d crash %0b",
                                           got.wall_seen, got.step_ok, got.x, got.y,
                                           got.heading, got.crashed));
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [CELL_W-1:0] cx,
                                input logic [CELL_W-1:0] cy, input logic [1:0] dir,
                                input logic present);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_action <= act;
        i_cell_x <= cx;
        i_cell_y <= cy;
        i_direction <= dir;
        i_wall_present <= present;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(act, cx, cy, dir, present));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_map_edges();
        send_request(ACT_QUERY_ABS, 4'd0, 4'd0, DIR_WEST, 1'b0);
        send_request(ACT_QUERY_ABS, 4'd0, 4'd0, DIR_SOUTH, 1'b1);
        send_request(ACT_QUERY_ABS, 4'd15, 4'd15, DIR_NORTH, 1'b0);
        send_request(ACT_QUERY_ABS, 4'd15, 4'd15, DIR_EAST, 1'b1);
        // off-map writes, ignored
        send_request(ACT_SET_WALL, 4'd15, 4'd15, DIR_NORTH, 1'b1);
        send_request(ACT_SET_WALL, 4'd15, 4'd2, DIR_EAST, 1'b1);
        // west edge reads as wall whatever is stored
        send_request(ACT_SET_WALL, 4'd0, 4'd4, DIR_WEST, 1'b0);
        send_request(ACT_QUERY_ABS, 4'd0, 4'd4, DIR_WEST, 1'b0);
        send_request(ACT_SET_WALL, 4'd7, 4'd9, DIR_SOUTH, 1'b1);
        send_request(ACT_QUERY_ABS, 4'd7, 4'd8, DIR_NORTH, 1'b0);
        send_request(ACT_SPARE_LO, 4'd15, 4'd15, DIR_WEST, 1'b1);
        send_request(ACT_SPARE_HI, 4'd0, 4'd0, DIR_NORTH, 1'b0);
        drain_results();
    endtask

    task automatic test_walker_moves();
        send_request(ACT_QUERY_REL, 4'd0, 4'd0, REL_BACK, 1'b0);
        send_request(ACT_QUERY_REL, 4'd0, 4'd0, REL_LEFT, 1'b0);
        send_request(ACT_STEP, 4'd0, 4'd0, REL_FRONT, 1'b0);
        send_request(ACT_TURN_REL, 4'd0, 4'd0, REL_RIGHT, 1'b0);
        send_request(ACT_STEP, 4'd0, 4'd0, REL_FRONT, 1'b0);
        send_request(ACT_TURN_ABS, 4'd0, 4'd0, DIR_NORTH, 1'b0);
        send_request(ACT_TURN_REL, 4'd0, 4'd0, REL_BACK, 1'b0);
        send_request(ACT_STEP, 4'd0, 4'd0, REL_FRONT, 1'b0);
        drain_results();
    endtask

    // steps into a wall are swapped for turns so the walker keeps moving
    task automatic test_random_walk(input int count, input int pct);
        int pick;
        logic [2:0] act;
        logic present;
        idle_pct = pct;
        repeat (count) begin
            pick = $urandom_range(99);
            present = $urandom_range(99) < 40;
            if (pick < 25) act = ACT_SET_WALL;
            else if (pick < 38) act = ACT_QUERY_ABS;
            else if (pick < 52) act = ACT_QUERY_REL;
            else if (pick < 62) act = ACT_TURN_REL;
            else if (pick < 70) act = ACT_TURN_ABS;
            else if (pick < 97) act = ACT_STEP;
            else act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            if (act == ACT_STEP && wall_toward(int'(walk_x), int'(walk_y), walk_heading))
                act = ACT_TURN_ABS;
            send_request(act, CELL_W'($urandom_range(GRID_SIDE - 1)),
                         CELL_W'($urandom_range(GRID_SIDE - 1)),
                         2'($urandom_range(3)), present);
        end
        drain_results();
    endtask

    task automatic test_crash();
        send_request(ACT_SET_WALL, walk_x, walk_y, walk_heading, 1'b1);
        send_request(ACT_STEP, 4'd0, 4'd0, REL_FRONT, 1'b0);
        send_request(ACT_TURN_REL, 4'd0, 4'd0, REL_RIGHT, 1'b0);
        send_request(ACT_TURN_ABS, 4'd0, 4'd0, walk_heading + 2'd2, 1'b0);
        send_request(ACT_STEP, 4'd0, 4'd0, REL_FRONT, 1'b1);
        send_request(ACT_QUERY_REL, 4'd0, 4'd0, REL_FRONT, 1'b0);
        drain_results();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_action <= ACT_SET_WALL;
        i_cell_x <= '0;
        i_cell_y <= '0;
        i_direction <= DIR_NORTH;
        i_wall_present <= 1'b0;
        for (int x = 0; x < GRID_SIDE; x++)
            for (int y = 0; y < GRID_SIDE; y++)
                wall_map[x][y] = 2'b00;
        walk_x = '0;
        walk_y = '0;
        walk_heading = DIR_NORTH;
        walk_crashed = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 11;
        test_map_edges();
        test_walker_moves();
        test_random_walk(200, 11);
        test_random_walk(200, 74);
        test_random_walk(200, 0);
        idle_pct = 11;
        test_crash();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
